>>> design/xrr_pkg.sv
// Shared types, constants and the xorshift step for the ranged random generator.
// No dependencies.
package xrr_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W = $clog2(DATA_W);
  localparam int SHIFT_A = 13;
  localparam int SHIFT_B = 17;
  localparam int SHIFT_C = 5;
  localparam logic [DATA_W-1:0] SEED_RESET = 32'd1234;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic [DATA_W-1:0] raw;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] span;
  } xrr_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_HOLD
  } back_state_t;

  function automatic logic [DATA_W-1:0] xs_advance(input logic [DATA_W-1:0] x);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = x ^ (x << SHIFT_A);
    b = a ^ (a >> SHIFT_B);
    return b ^ (b << SHIFT_C);
  endfunction

endpackage

>>> design/xrr_front.sv
// Front end: takes requests, steps the xorshift state, forms the span.
// Depends on xrr_pkg.
module xrr_front import xrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_range_low,
  input  logic [DATA_W-1:0] in_range_high,
  input  q_stat_t           q_stat,
  output logic              push,
  output xrr_item_t         push_item
);

  logic [DATA_W-1:0] state_r;
  logic [DATA_W-1:0] state_nxt;
  logic [DATA_W-1:0] raw;

  assign raw = xs_advance(state_r);
  assign in_ready = !q_stat.full;
  assign push = in_valid && in_ready;

  always_comb begin
    push_item.raw = raw;
    push_item.low = in_range_low;
    push_item.span = in_range_high - in_range_low + DATA_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = cfg_wdata;
    end else if (push) begin
      state_nxt = raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEED_RESET;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/xrr_queue.sv
// Small item queue between front and back ends.
// Depends on xrr_pkg.
module xrr_queue import xrr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  xrr_item_t push_item,
  input  logic      pop,
  output xrr_item_t pop_item,
  output q_stat_t   q_stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  xrr_item_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW-1:0]   rd_ptr_nxt;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;

  assign q_stat.full = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

>>> design/xrr_back.sv
// Back end: restoring radix-2 modulo, one quotient bit a cycle, and result register.
// Depends on xrr_pkg.
module xrr_back import xrr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  q_stat_t           q_stat,
  input  xrr_item_t         pop_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_raw_value,
  output logic [DATA_W-1:0] out_ranged_value,
  output logic              out_hit_low
);

  back_state_t       state_r;
  back_state_t       state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] dvd_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] rem_nxt;
  logic [DATA_W-1:0] span_r;
  logic [DATA_W-1:0] low_r;
  logic [DATA_W-1:0] raw_r;
  logic [DATA_W:0]   trial;

  // a zero span subtracts nothing, so the remainder ends as the raw word
  always_comb begin
    trial = {rem_r, dvd_r[DATA_W-1]};
    if (trial >= {1'b0, span_r}) begin
      trial = trial - {1'b0, span_r};
    end
    rem_nxt = trial[DATA_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = B_RUN;
        end
      end
      B_RUN: begin
        if (cnt_r == '0) begin
          state_nxt = B_HOLD;
        end
      end
      B_HOLD: begin
        if (out_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state_r == B_IDLE) && !q_stat.empty;
    out_valid = (state_r == B_HOLD);
  end

  assign out_raw_value = raw_r;
  assign out_ranged_value = rem_r + low_r;
  assign out_hit_low = (rem_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        cnt_r <= CNT_W'(DATA_W - 1);
      end else if (state_r == B_RUN) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dvd_r <= pop_item.raw;
      raw_r <= pop_item.raw;
      span_r <= pop_item.span;
      low_r <= pop_item.low;
      rem_r <= '0;
    end else if (state_r == B_RUN) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

endmodule

>>> design/xorshift32_ranged_random_top.sv
// Top level of the ranged xorshift32 generator: front end, item queue, modulo back end.
// Depends on xrr_pkg, xrr_front, xrr_queue, xrr_back.
//
//   channel | signals                                         | direction
//   in      | in_valid, in_ready, in_range_low, in_range_high  | request in
//   out     | out_valid, out_ready, out_raw_value,             | result out
//           | out_ranged_value, out_hit_low                    |
//   cfg     | cfg_we, cfg_wdata (seed, loads the state)        | write only
//
// In the back end an item is loaded from the queue, goes through 32 modulo steps, then is handed off.
// The bit-serial modulo unit sets the rate; the queue takes items up to QUEUE_DEPTH ahead.
// Synchronous active-low reset loads the state with 1234 and empties the queue.
// A stalled result holds the back end; the front keeps taking items until the queue fills.
module xorshift32_ranged_random_top import xrr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] in_range_low,
  input  logic signed [DATA_W-1:0] in_range_high,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [DATA_W-1:0]        out_raw_value,
  output logic signed [DATA_W-1:0] out_ranged_value,
  output logic                     out_hit_low
);

  q_stat_t   q_stat;
  logic      push;
  logic      pop;
  xrr_item_t push_item;
  xrr_item_t pop_item;
  logic [DATA_W-1:0] ranged_u;

  xrr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_range_low (in_range_low),
    .in_range_high(in_range_high),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  xrr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .pop_item (pop_item),
    .q_stat   (q_stat)
  );

  xrr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .pop_item        (pop_item),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_raw_value   (out_raw_value),
    .out_ranged_value(ranged_u),
    .out_hit_low     (out_hit_low)
  );

  assign out_ranged_value = ranged_u;

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("push into full queue");

  a_accept_queues: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !q_stat.empty) else $error("accepted item not queued");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> !out_valid) else $error("result repeated");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> !out_valid) else $error("pop while result pending");
`endif

endmodule
